FILE: rtl/bol_pkg.sv
package bol_pkg;

  // default capacity of the list
  localparam int BOL_DEPTH = 16;

  // request codes, the codes above remove-at do nothing
  typedef enum logic [2:0] {
    ACT_INSERT_FRONT = 3'd0,
    ACT_INSERT_BACK  = 3'd1,
    ACT_REMOVE_FRONT = 3'd2,
    ACT_REMOVE_BACK  = 3'd3,
    ACT_REMOVE_AT    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // what every cell of the chain does at a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,
    CELL_WRITE_AT  = 2'd2,
    CELL_REMOVE_AT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_cmd_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
    logic [4:0]         position;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [4:0]         count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } result_t;

endpackage

FILE: rtl/bol_cell.sv
module bol_cell
  import bol_pkg::*;
#(
  parameter int DEPTH = BOL_DEPTH,
  parameter int INDEX = 0,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [IDX_W-1:0]   idx,
  input  logic [IDX_W-1:0]   last_idx,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  output logic signed [31:0] data,
  output logic signed [31:0] tail
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  // element storage, moves with the neighbors on shifts
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_SHIFT_IN: data <= left_data;
      CELL_WRITE_AT: begin
        if (MY_IDX == idx) data <= cmd.value;
      end
      CELL_REMOVE_AT: begin
        if (MY_IDX >= idx) data <= right_data;
      end
      default: data <= data;
    endcase
  end

  // this cell's share of the back value
  assign tail = (MY_IDX == last_idx) ? data : 32'sd0;

endmodule

FILE: rtl/bounded_ordered_list_top.sv
// Bounded ordered list of up to DEPTH signed 32-bit values held in a chain
// of cells. A request (insert front/back, remove front/back, remove at a
// 1-based position) is taken at any clock edge where start is high and
// busy is low; busy is high during reset and clears at the first edge
// with reset low. Every request gives exactly one result on the result
// port, marked by done for one cycle, in the cycle right after the request
// was accepted. The receiver cannot stall: it must take the result in that
// cycle. Throughput is one request per cycle while busy is low, since all
// cells shift in parallel in the acceptance cycle; the cell and length
// registers hold the result. Rejected requests (full, empty, position out
// of range) return their status and leave the list untouched.
module bounded_ordered_list_top
  import bol_pkg::*;
#(
  parameter int DEPTH = BOL_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

  logic [LEN_W-1:0]   length;
  logic [LEN_W-1:0]   length_next;
  status_t            status;
  status_t            status_next;
  logic               accept;
  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   len_ext;
  logic signed [31:0] cell_data [DEPTH];
  logic signed [31:0] cell_tail [DEPTH];
  logic signed [31:0] tail_or;

  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(request.position);
  assign len_ext = CMP_W'(length);

  // request decode into a chain command
  always_comb begin
    status_next = ST_OK;
    length_next = length;
    cmd.op      = CELL_HOLD;
    cmd.value   = request.value;
    idx         = '0;
    case (request.action)
      ACT_INSERT_FRONT: begin
        if (length >= FULL_LEN) begin
          status_next = ST_FULL;
        end else begin
          cmd.op      = CELL_SHIFT_IN;
          length_next = length + LEN_W'(1);
        end
      end
      ACT_INSERT_BACK: begin
        if (length >= FULL_LEN) begin
          status_next = ST_FULL;
        end else begin
          cmd.op      = CELL_WRITE_AT;
          idx         = IDX_W'(length);
          length_next = length + LEN_W'(1);
        end
      end
      ACT_REMOVE_FRONT: begin
        if (length == '0) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.op      = CELL_REMOVE_AT;
          length_next = length - LEN_W'(1);
        end
      end
      ACT_REMOVE_BACK: begin
        if (length == '0) begin
          status_next = ST_EMPTY;
        end else begin
          length_next = length - LEN_W'(1);
        end
      end
      ACT_REMOVE_AT: begin
        if (length == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > len_ext) begin
          status_next = ST_RANGE;
        end else begin
          cmd.op      = CELL_REMOVE_AT;
          idx         = IDX_W'(pos_ext - CMP_W'(1));
          length_next = length - LEN_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    if (!accept) begin
      cmd.op      = CELL_HOLD;
      length_next = length;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      done   <= 1'b0;
      busy   <= 1'b1;
      status <= ST_OK;
    end else begin
      length <= length_next;
      done   <= accept;
      busy   <= 1'b0;
      if (accept) status <= status_next;
    end
  end

  assign last_idx = IDX_W'(length - LEN_W'(1));

  // chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end
    bol_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx),
      .last_idx   (last_idx),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .tail       (cell_tail[g])
    );
  end

  // back value: only the cell at last_idx, the last occupied one when the list is not empty, drives a nonzero share
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_or = tail_or | cell_tail[i];
    end
  end

  // result fields
  always_comb begin
    result.status      = status;
    result.count       = 5'(length);
    result.front_value = (length != '0) ? cell_data[0] : 32'sd0;
    result.back_value  = (length != '0) ? tail_or : 32'sd0;
  end

  // every accepted request gives a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> done)
    else $error("accepted request without a result");

  // a rejected request leaves the length alone
  assert property (@(posedge clk) disable iff (rst)
    accept && status_next != ST_OK |=> length == $past(length))
    else $error("rejected request changed the length");

  // full status only when the list really is full
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> length == FULL_LEN)
    else $error("full status with room left");

  // length never exceeds capacity
  assert property (@(posedge clk) disable iff (rst) length <= FULL_LEN)
    else $error("length beyond capacity");

  // a good insert grows the list by one
  assert property (@(posedge clk) disable iff (rst)
    accept && status_next == ST_OK &&
    (request.action == ACT_INSERT_FRONT || request.action == ACT_INSERT_BACK)
    |=> length == $past(length) + LEN_W'(1))
    else $error("insert did not grow the list");

endmodule

FILE: test/bounded_ordered_list_top_tb.sv
import bol_pkg::*;

// tracks the list contents and the results still owed by the block
class list_scoreboard;
  logic signed [31:0] cells[BOL_DEPTH];
  int unsigned        len;
  result_t            owed_q[$];
  int                 errors;

  function new();
    len    = 0;
    errors = 0;
    foreach (cells[i]) cells[i] = '0;
  endfunction

  // close the gap left by the element at idx
  function void drop_cell(int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < len; i++) cells[i] = cells[i + 1];
    len--;
  endfunction

  // apply one accepted transaction to the list and queue its result
  function void note_request(request_t req);
    result_t     want;
    status_t     st;
    int unsigned i;
    st = ST_OK;
    case (req.action)
      ACT_INSERT_FRONT: begin
        if (len >= BOL_DEPTH) begin
          st = ST_FULL;
        end else begin
          for (i = len; i > 0; i--) cells[i] = cells[i - 1];
          cells[0] = req.value;
          len++;
        end
      end
      ACT_INSERT_BACK: begin
        if (len >= BOL_DEPTH) begin
          st = ST_FULL;
        end else begin
          cells[len] = req.value;
          len++;
        end
      end
      ACT_REMOVE_FRONT: begin
        if (len == 0) st = ST_EMPTY;
        else drop_cell(0);
      end
      ACT_REMOVE_BACK: begin
        if (len == 0) st = ST_EMPTY;
        else len--;
      end
      ACT_REMOVE_AT: begin
        if (len == 0) st = ST_EMPTY;
        else if (req.position == 0 || req.position > len) st = ST_RANGE;
        else drop_cell(req.position - 1);
      end
      default: ;
    endcase
    want.status = st;
    want.count  = len[4:0];
    if (len == 0) begin
      want.front_value = '0;
      want.back_value  = '0;
    end else begin
      want.front_value = cells[0];
      want.back_value  = cells[len - 1];
    end
    owed_q.push_back(want);
  endfunction

  task report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // compare one result with the oldest owed one
  task check_result(result_t got);
    result_t want;
    if (owed_q.size() == 0) begin
      report_mismatch("result with no transaction pending");
      return;
    end
    want = owed_q.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.count !== want.count)
      report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
    if (got.front_value !== want.front_value)
      report_mismatch($sformatf("front got %0d want %0d",
                                got.front_value, want.front_value));
    if (got.back_value !== want.back_value)
      report_mismatch($sformatf("back got %0d want %0d",
                                got.back_value, want.back_value));
  endtask
endclass

module bounded_ordered_list_top_tb;

  localparam logic [2:0]         ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0]         ACT_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] VAL_MAX       = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN       = 32'sh8000_0000;
  localparam int                 RANDOM_ITEMS  = 550;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  list_scoreboard list_sb;
  int             sent;

  bounded_ordered_list_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #2000000;
    $display("[bounded_ordered_list_top] ERROR");
    $finish;
  end

  // result checking, every strobed result must be taken
  always @(posedge clk) begin
    if (!rst && done) list_sb.check_result(result);
  end

  function automatic request_t mk(action_t act, logic signed [31:0] val, logic [4:0] pos);
    request_t r;
    r.action   = act;
    r.value    = val;
    r.position = pos;
    return r;
  endfunction

  // values lean toward the extremes, zero and -1 now and then
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // random transaction, insert and remove percentages set the phase
  function automatic request_t pick_request(int ins_pct, int rm_pct);
    request_t r;
    int       roll;
    roll       = $urandom_range(0, 99);
    r.value    = pick_value();
    r.position = 5'($urandom_range(0, 31));
    if (roll < ins_pct) begin
      r.action = $urandom_range(0, 1) ? ACT_INSERT_FRONT : ACT_INSERT_BACK;
    end else if (roll < ins_pct + rm_pct) begin
      case ($urandom_range(0, 2))
        0: r.action = ACT_REMOVE_FRONT;
        1: r.action = ACT_REMOVE_BACK;
        default: begin
          r.action = ACT_REMOVE_AT;
          if (list_sb.len > 0 && $urandom_range(0, 9) < 8)
            r.position = 5'($urandom_range(1, list_sb.len));
        end
      endcase
    end else if ($urandom_range(0, 1)) begin
      r.action = action_t'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end else begin
      r.action = ACT_REMOVE_AT;
    end
    return r;
  endfunction

  // hold a transaction on the port until the block takes it
  task automatic send(request_t req);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    list_sb.note_request(req);
    sent++;
  endtask

  // sender gap with junk on the request port
  task automatic idle(int cycles);
    start   <= 1'b0;
    request <= 40'({$urandom, $urandom});
    repeat (cycles) @(posedge clk);
  endtask

  // let every owed result come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (list_sb.owed_q.size() != 0);
  endtask

  initial begin
    int code;
    int ins_pct;
    int rm_pct;
    int phase_len;
    int burst;
    int phase_cnt;
    list_sb   = new();
    sent      = 0;
    phase_cnt = 0;
    rst       = 1'b1;
    start     = 1'b0;
    request   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // removes on an empty list, empty wins over a bad position
    send(mk(ACT_REMOVE_FRONT, $urandom, 5'($urandom)));
    send(mk(ACT_REMOVE_BACK, $urandom, 5'($urandom)));
    send(mk(ACT_REMOVE_AT, $urandom, 5'd0));
    // unused codes do nothing
    for (code = ACT_UNUSED_LO; code <= ACT_UNUSED_HI; code++)
      send(mk(action_t'(code), $urandom, 5'($urandom)));
    // build 0, max, min, -1
    send(mk(ACT_INSERT_FRONT, VAL_MAX, 5'($urandom)));
    send(mk(ACT_INSERT_BACK, VAL_MIN, 5'($urandom)));
    send(mk(ACT_INSERT_FRONT, '0, 5'($urandom)));
    send(mk(ACT_INSERT_BACK, -32'sd1, 5'($urandom)));
    // positions outside 1..count
    send(mk(ACT_REMOVE_AT, $urandom, 5'd0));
    send(mk(ACT_REMOVE_AT, $urandom, 5'd5));
    send(mk(ACT_REMOVE_AT, $urandom, 5'd31));
    // middle, last, back, only element, then front
    send(mk(ACT_REMOVE_AT, $urandom, 5'd2));
    send(mk(ACT_REMOVE_AT, $urandom, 5'd3));
    send(mk(ACT_REMOVE_BACK, $urandom, 5'($urandom)));
    send(mk(ACT_REMOVE_AT, $urandom, 5'd1));
    send(mk(ACT_INSERT_FRONT, 32'shaaaa_aaaa, 5'd16));
    send(mk(ACT_REMOVE_FRONT, $urandom, 5'($urandom)));
    idle($urandom_range(1, 4));

    // random phases: fill, drain or mixed, sent in bursts
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin ins_pct = 85; rm_pct = 10; end
        1: begin ins_pct = 10; rm_pct = 85; end
        default: begin ins_pct = 45; rm_pct = 45; end
      endcase
      phase_len = $urandom_range(8, 40);
      while (phase_len > 0) begin
        burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        while (burst > 0 && phase_len > 0) begin
          send(pick_request(ins_pct, rm_pct));
          burst--;
          phase_len--;
        end
        if ($urandom_range(0, 9) < 7) idle($urandom_range(1, 6));
      end
      phase_cnt++;
      if (phase_cnt % 5 == 0) drain();
    end

    // wait out the owed results, then watch for stray results before the verdict
    drain();
    repeat (4) @(posedge clk);
    if (list_sb.errors == 0) begin
      $display("[bounded_ordered_list_top] OK");
    end else begin
      $display("[bounded_ordered_list_top] ERROR");
    end
    $finish;
  end

endmodule
